@@ sv/i2rs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2rs_pkg
// Shared constants and types for the integer to radix string converter.
// ----------------------------------------------------------------------------
package i2rs_pkg;

   // Default width of the signed input value.
   localparam int VALUE_BITS_DEFAULT = 32;

   // Field widths.
   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 8;

   // Valid range of the number base.
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   // ASCII codes used for the text.
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   // First digit value that maps to a letter.
   localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

   // Quotient bits resolved per cycle by the divider.
   localparam int DIV_BITS = 4;

   // Number of entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Classification of one accepted item.
   typedef struct packed {
      logic               neg;
      logic               bad;
      logic [RADIX_W-1:0] radix;
   } i2rs_ctl_type;

   localparam int CTL_W = $bits(i2rs_ctl_type);

endpackage

@@ sv/i2rs_front.sv @@
// ----------------------------------------------------------------------------
// i2rs_front
// Classifies an incoming item: checks the base and forms the magnitude.
// ----------------------------------------------------------------------------
module i2rs_front #(
   parameter int VALUE_BITS = i2rs_pkg::VALUE_BITS_DEFAULT
) (
   input  logic [VALUE_BITS-1:0]        value,
   input  logic [i2rs_pkg::RADIX_W-1:0] radix,
   output logic [VALUE_BITS-1:0]        mag,
   output i2rs_pkg::i2rs_ctl_type       ctl
);
   import i2rs_pkg::*;

   // The sign bit selects the two's complement negation; the most negative
   // value maps onto itself, which is its correct unsigned magnitude.
   always_comb begin
      ctl.neg   = value[VALUE_BITS-1];
      ctl.bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
      ctl.radix = radix;
      mag       = ctl.neg ? (~value + VALUE_BITS'(1)) : value;
   end

endmodule

@@ sv/i2rs_queue.sv @@
// ----------------------------------------------------------------------------
// i2rs_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module i2rs_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = i2rs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   import i2rs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ sv/i2rs_back.sv @@
// ----------------------------------------------------------------------------
// i2rs_back
// Divides the magnitude by the base digit by digit, stacks the digits and
// sends them out most significant first through an output register.
// ----------------------------------------------------------------------------
module i2rs_back #(
   parameter int VALUE_BITS = i2rs_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  logic [VALUE_BITS-1:0]       q_mag,
   input  i2rs_pkg::i2rs_ctl_type      q_ctl,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [i2rs_pkg::CHAR_W-1:0] out_char,
   output logic                        out_last,
   output logic                        out_bad
);
   import i2rs_pkg::*;

   localparam int MAG_W  = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
   localparam int STEPS  = MAG_W / DIV_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W  = $clog2(VALUE_BITS);
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_SEND,
      ST_ERR
   } state_type;

   state_type           state_ff;
   logic [MAG_W-1:0]    work_ff;
   logic [RADIX_W-1:0]  rem_ff;
   logic [RADIX_W-1:0]  radix_ff;
   logic                neg_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                out_valid_ff;
   logic [CHAR_W-1:0]   out_char_ff;
   logic                out_last_ff;
   logic                out_bad_ff;

   logic [CHAR_W-1:0]   stack_mem [VALUE_BITS];
   logic [CHAR_W-1:0]   rd_char_ff;

   logic [MAG_W-1:0]    work_in;
   logic [RADIX_W-1:0]  rem_in;
   logic [CHAR_W-1:0]   digit_char;
   logic                out_free;
   logic                out_load;
   logic                out_valid_in;
   logic                digit_done;
   logic                stack_wr;
   logic [IDX_W-1:0]    top_idx;

   assign out_free   = !out_valid_ff || out_ready;
   assign q_ready    = (state_ff == ST_IDLE);
   assign digit_done = (state_ff == ST_DIV) && (step_ff == STEP_W'(STEPS - 1));
   assign stack_wr   = digit_done;
   assign top_idx    = cnt_ff[IDX_W-1:0] - IDX_W'(1);

   // The output register takes a new beat from the sign, send and error
   // states; otherwise it holds its beat until the sink accepts it.
   assign out_load     = out_free && (((state_ff == ST_SIGN) && neg_ff)
                         || (state_ff == ST_SEND) || (state_ff == ST_ERR));
   assign out_valid_in = out_load || (out_valid_ff && !out_ready);

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;
   assign out_bad   = out_bad_ff;

   // Restoring division, DIV_BITS quotient bits per cycle. The dividend
   // shifts out at the top while quotient bits shift in at the bottom.
   always_comb begin
      logic [RADIX_W:0] trial;
      logic             ge;
      work_in = work_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial   = {rem_in, work_in[MAG_W-1]};
         ge      = (trial >= {1'b0, radix_ff});
         rem_in  = ge ? RADIX_W'(trial - {1'b0, radix_ff}) : trial[RADIX_W-1:0];
         work_in = {work_in[MAG_W-2:0], ge};
      end
   end

   // Digit value to its ASCII character.
   always_comb begin
      if (rem_in < DIGIT_TEN) begin
         digit_char = CHAR_ZERO + CHAR_W'(rem_in);
      end else begin
         digit_char = CHAR_A + CHAR_W'(rem_in - DIGIT_TEN);
      end
   end

   // Digit stack, least significant digit at the bottom.
   always_ff @(posedge clock) begin
      if (stack_wr) begin
         stack_mem[cnt_ff[IDX_W-1:0]] <= digit_char;
      end
      rd_char_ff <= stack_mem[top_idx];
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  work_ff  <= MAG_W'(q_mag);
                  rem_ff   <= '0;
                  radix_ff <= q_ctl.radix;
                  neg_ff   <= q_ctl.neg;
                  step_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= q_ctl.bad ? ST_ERR : ST_DIV;
               end
            end
            ST_DIV: begin
               if (digit_done) begin
                  cnt_ff  <= cnt_ff + CNT_W'(1);
                  step_ff <= '0;
                  rem_ff  <= '0;
                  work_ff <= work_in;
                  if (work_in == '0) begin
                     state_ff <= ST_SIGN;
                  end
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
                  rem_ff  <= rem_in;
                  work_ff <= work_in;
               end
            end
            ST_SIGN: begin
               if (!neg_ff) begin
                  state_ff <= ST_READ;
               end else if (out_free) begin
                  out_char_ff  <= CHAR_MINUS;
                  out_last_ff  <= 1'b0;
                  out_bad_ff   <= 1'b0;
                  state_ff     <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_free) begin
                  out_char_ff  <= rd_char_ff;
                  out_last_ff  <= (cnt_ff == CNT_W'(1));
                  out_bad_ff   <= 1'b0;
                  cnt_ff       <= cnt_ff - CNT_W'(1);
                  state_ff     <= (cnt_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
               end
            end
            ST_ERR: begin
               if (out_free) begin
                  out_char_ff  <= CHAR_NUL;
                  out_last_ff  <= 1'b1;
                  out_bad_ff   <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ sv/integer_to_radix_string.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts a signed integer to its ASCII text in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One request carries a signed value and a base; the response stream carries
// the text one character per beat, a '-' first for a negative value, then
// the digits most significant first, with tlast on the final character. A
// base outside 2..36 gives a single beat with a null character and tuser set.
// Each digit is found by the shared divider, which resolves four quotient
// bits per cycle, and each character is then read from the digit stack and
// sent. A two-entry queue lets the request side accept items while the
// divider is busy.
// ----------------------------------------------------------------------------
module integer_to_radix_string #(
   parameter int VALUE_BITS = i2rs_pkg::VALUE_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // Fields from bit 0 up: value, radix, zero padding.
   input  logic [((VALUE_BITS + i2rs_pkg::RADIX_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: text_char.
   output logic [i2rs_pkg::CHAR_W-1:0] rsp_tdata,
   // Fields from bit 0 up: bad_radix.
   output logic [0:0] rsp_tuser,
   output logic rsp_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready
);
   import i2rs_pkg::*;

   localparam int ENTRY_W = CTL_W + VALUE_BITS;

   logic [VALUE_BITS-1:0] req_value;
   logic [RADIX_W-1:0]    req_radix;
   logic [VALUE_BITS-1:0] front_mag;
   i2rs_ctl_type          front_ctl;
   logic [ENTRY_W-1:0]    q_data;
   logic                  q_valid;
   logic                  q_ready;
   logic                  out_bad;

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign req_radix = req_tdata[VALUE_BITS +: RADIX_W];

   // Classification of the request.
   i2rs_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .value (req_value),
      .radix (req_radix),
      .mag   (front_mag),
      .ctl   (front_ctl)
   );

   // Queue between classification and conversion.
   i2rs_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({front_ctl, front_mag}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   // Division and character output.
   i2rs_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_mag     (q_data[VALUE_BITS-1:0]),
      .q_ctl     (q_data[ENTRY_W-1:VALUE_BITS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_bad   (out_bad)
   );

   assign rsp_tuser = out_bad;

endmodule

@@ sv/i2rs_checker.sv @@
// ----------------------------------------------------------------------------
// i2rs_checker
// Port-level checks on the response stream of the converter.
// ----------------------------------------------------------------------------
module i2rs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic [i2rs_pkg::CHAR_W-1:0] rsp_tdata,
   input logic [0:0]                  rsp_tuser,
   input logic                        rsp_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready
);
   import i2rs_pkg::*;

   // An error beat stands alone and carries a null character.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == CHAR_NUL))
      else $error("error beat is not a single null character");

   // Every beat that is not an error carries a non-null character.
   a_char_nonnull: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata != CHAR_NUL)
      else $error("text beat carries a null character");

   // A minus sign is never the final character.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign marked as last character");

   // A stalled beat holds its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

endmodule

bind integer_to_radix_string i2rs_checker u_i2rs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
